>>> design/bhc_pkg.sv
// Shared types, constants and helpers for the bitstream header checker.
package bhc_pkg;

    // Stream widths (payload padded to whole bytes)
    localparam int IN_DATA_BITS  = 8;
    localparam int OUT_DATA_BITS = 104;

    // Header layout
    localparam int HEADER_BYTES = 16;
    localparam int MAGIC_BYTES  = 4;
    localparam int SIZE_END     = 8;
    localparam int SUM_END      = 12;
    localparam int SYNC_AT      = HEADER_BYTES + 'h04;
    localparam int ID_AT        = HEADER_BYTES + 'h24;
    localparam int WORD_BYTES   = 4;

    localparam logic [7:0] MAGIC [MAGIC_BYTES] = '{8'h46, 8'h50, 8'h47, 8'h41};

    localparam int NUM_KNOWN_IDS = 5;
    localparam logic [31:0] KNOWN_IDS [NUM_KNOWN_IDS] = '{
        32'h01C10093, 32'h01C1A093, 32'h01C22093, 32'h01C2E093, 32'h01C3A093
    };

    // Verdict codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_MAGIC = 2'd1;
    localparam logic [1:0] STATUS_BAD_SIZE = 2'd2;
    localparam logic [1:0] STATUS_BAD_SUM  = 2'd3;

    localparam logic [2:0] KIND_UNKNOWN = 3'd0;

    // Result transaction, status in the lowest bits
    typedef struct packed {
        logic [2:0]  pad;
        logic [2:0]  device_kind;
        logic [31:0] device_id;
        logic [31:0] sync_pattern;
        logic [31:0] computed_sum;
        logic [1:0]  status;
    } result_t;

    // Bit reversal of one byte
    function automatic logic [7:0] flip8(input logic [7:0] b);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[k] = b[7 - k];
        end
        return r;
    endfunction

endpackage

>>> design/bitstream_header_checker.sv
// Top level: byte-stream header check, payload checksum and field capture.
//
//  channel | dir | tdata (low bit up)                                   | tlast
//  s_axis  | in  | data_byte[7:0]                                       | last_byte
//  m_axis  | out | status[1:0] computed_sum[33:2] sync_pattern[65:34]   | -
//          |     | device_id[97:66] device_kind[100:98] zero[103:101]   |
//
// One byte per cycle, except that a last byte waits while a result is stalled; a
// verdict goes from the input register directly into the result register.
// Per-byte work is a compare, a byte capture and one 32-bit add into the sum.
// aresetn resets the valid flags and the file state; after each verdict the file state returns to reset.
// A stalled result only holds back a last byte; other bytes keep flowing.
module bitstream_header_checker #(
    parameter int COUNT_BITS = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [bhc_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,   // data_byte
    input  logic                                s_axis_tlast,   // last_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [bhc_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata    // see table above
);
    import bhc_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Input register
    logic                    in_valid_reg;
    logic [7:0]              in_byte_reg;
    logic                    in_last_reg;

    // File state
    logic [COUNT_BITS-1:0]   count_reg,  count_next;
    logic                    magic_reg,  magic_next;
    logic [31:0]             size_reg,   size_next;
    logic [31:0]             hsum_reg,   hsum_next;
    logic [31:0]             sum_reg,    sum_next;
    logic [31:0]             sync_reg,   sync_next;
    logic [31:0]             id_reg,     id_next;

    // Result register
    logic                    out_valid_reg;
    result_t                 out_reg;
    result_t                 result;

    logic                    proc_ready;
    logic                    proc_fire;

    // Non-last bytes never wait on the result side
    assign proc_ready    = !out_valid_reg || m_axis_tready || !in_last_reg;
    assign proc_fire     = in_valid_reg && proc_ready;
    assign s_axis_tready = !in_valid_reg || proc_ready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // Per-byte state update and verdict
    always_comb begin
        magic_next = magic_reg;
        if (count_reg < COUNT_BITS'(MAGIC_BYTES)) begin
            if (in_byte_reg != MAGIC[count_reg[1:0]]) begin
                magic_next = 1'b0;
            end
        end

        size_next = size_reg;
        hsum_next = hsum_reg;
        if (count_reg >= COUNT_BITS'(MAGIC_BYTES) && count_reg < COUNT_BITS'(SIZE_END)) begin
            size_next = {size_reg[23:0], in_byte_reg};
        end else if (count_reg >= COUNT_BITS'(SIZE_END)
                     && count_reg < COUNT_BITS'(SUM_END)) begin
            hsum_next = {hsum_reg[23:0], in_byte_reg};
        end

        sum_next = sum_reg;
        if (count_reg >= COUNT_BITS'(HEADER_BYTES)) begin
            sum_next = sum_reg + {24'd0, in_byte_reg};
        end

        sync_next = sync_reg;
        if (count_reg >= COUNT_BITS'(SYNC_AT)
            && count_reg < COUNT_BITS'(SYNC_AT + WORD_BYTES)) begin
            sync_next = {sync_reg[23:0], flip8(in_byte_reg)};
        end

        id_next = id_reg;
        if (count_reg >= COUNT_BITS'(ID_AT) && count_reg < COUNT_BITS'(ID_AT + WORD_BYTES)) begin
            id_next = {id_reg[23:0], flip8(in_byte_reg)};
        end

        count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

        // Length after this byte is count_reg + 1 (short of saturation)
        result.pad          = '0;
        result.computed_sum = sum_next;
        result.sync_pattern = sync_next;
        result.device_id    = id_next;
        if (count_reg < COUNT_BITS'(MAGIC_BYTES - 1) || !magic_next) begin
            result.status = STATUS_BAD_MAGIC;
        end else if (count_reg < COUNT_BITS'(HEADER_BYTES - 1)
                     || count_reg >= COUNT_MAX - 1'b1
                     || size_next != 32'(count_reg) - 32'(HEADER_BYTES - 1)) begin
            result.status = STATUS_BAD_SIZE;
        end else if (hsum_next != sum_next) begin
            result.status = STATUS_BAD_SUM;
        end else begin
            result.status = STATUS_OK;
        end

        result.device_kind = KIND_UNKNOWN;
        for (int k = 0; k < NUM_KNOWN_IDS; k++) begin
            if (id_next == KNOWN_IDS[k]) begin
                result.device_kind = 3'(k + 1);
            end
        end
    end

    // File state registers, back to reset after each verdict
    always_ff @(posedge aclk) begin
        if (!aresetn || (proc_fire && in_last_reg)) begin
            count_reg <= '0;
            magic_reg <= 1'b1;
            size_reg  <= '0;
            hsum_reg  <= '0;
            sum_reg   <= '0;
            sync_reg  <= '0;
            id_reg    <= '0;
        end else if (proc_fire) begin
            count_reg <= count_next;
            magic_reg <= magic_next;
            size_reg  <= size_next;
            hsum_reg  <= hsum_next;
            sum_reg   <= sum_next;
            sync_reg  <= sync_next;
            id_reg    <= id_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (proc_fire && in_last_reg) begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

endmodule

>>> design/bhc_checker.sv
// Port-level checks for the bitstream header checker, bound to the top level.
module bhc_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [bhc_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata
);
    import bhc_pkg::*;

    result_t res;
    logic    kind_matches;

    assign res = m_axis_tdata;

    // Device kind must agree with the captured ID
    always_comb begin
        kind_matches = (res.device_kind == KIND_UNKNOWN);
        for (int k = 0; k < NUM_KNOWN_IDS; k++) begin
            if (res.device_id == KNOWN_IDS[k]) begin
                kind_matches = (res.device_kind == 3'(k + 1));
            end
        end
    end

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Input is only held off while a verdict waits on a stalled output
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a waiting verdict");

    // Kind code consistent with the reported ID
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> kind_matches)
        else $error("device kind does not match device ID");

    // Padding bits stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> res.pad == '0)
        else $error("nonzero padding in result");

    // No result straight out of reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind bitstream_header_checker bhc_checker u_bhc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
